// ----- hw/rtl/gpb_pkg.sv -----
// gpb_pkg: shared constants and types for the ground plane box estimator
// used by the front, back and top modules of the block; depends on nothing
package gpb_pkg;

	localparam int COORD_BITS_DEF = 12;
	localparam int OUT_FRAC_BITS_DEF = 16;

	localparam int CFG_IDX_BITS = 2;
	localparam int CFG_DATA_BITS = 20;

	localparam logic [CFG_IDX_BITS-1:0] REG_HALF_W = 2'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_HALF_H = 2'd1;
	localparam logic [CFG_IDX_BITS-1:0] REG_FOCAL = 2'd2;
	localparam logic [CFG_IDX_BITS-1:0] REG_CAM_H = 2'd3;

	localparam logic [10:0] HALF_W_RST = 11'd320;
	localparam logic [10:0] HALF_H_RST = 11'd240;
	localparam logic [19:0] FOCAL_RST = 20'd141890;
	localparam logic [17:0] CAM_H_RST = 18'd20972;

	// numerator magnitude width: 18 bit height times up to 31 bit multiplier
	localparam int NUM_BITS = 50;
	// denominator width: dy (16 magnitude bits) shifted left by up to 18
	localparam int DEN_BITS = 34;
	localparam int NUM_OUTS = 5;

	typedef enum logic [1:0] {
		DIV_IDLE,
		DIV_LOAD,
		DIV_RUN,
		DIV_DONE
	} div_state_t;

	function automatic logic [31:0] sat_round(input logic neg, input logic [NUM_BITS-1:0] q);
		logic [31:0] r;
		if (neg) begin
			if (q > NUM_BITS'(64'd2147483648)) r = 32'h8000_0000;
			else r = 32'(~q[31:0] + 32'd1);
		end else begin
			if (q > NUM_BITS'(64'd2147483647)) r = 32'h7FFF_FFFF;
			else r = q[31:0];
		end
		return r;
	endfunction

endpackage

// ----- hw/rtl/gpb_front.sv -----
// gpb_front: accepts polygon points and tracks the bounding rows and columns
// emits one closed polygon per last point; depends on gpb_pkg
module gpb_front #(
	parameter int COORD_BITS = gpb_pkg::COORD_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic in_take,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic last_point,
	output logic close_pulse,
	output logic signed [COORD_BITS-1:0] min_x,
	output logic signed [COORD_BITS-1:0] max_x,
	output logic signed [COORD_BITS-1:0] min_y,
	output logic signed [COORD_BITS-1:0] max_y
);

	logic open_q;
	logic signed [COORD_BITS-1:0] min_x_q, max_x_q, min_y_q, max_y_q;
	logic signed [COORD_BITS-1:0] nmin_x, nmax_x, nmin_y, nmax_y;

	always_comb begin
		if (!open_q) begin
			nmin_x = point_x;
			nmax_x = point_x;
			nmin_y = point_y;
			nmax_y = point_y;
		end else begin
			nmin_x = (point_x < min_x_q) ? point_x : min_x_q;
			nmax_x = (point_x > max_x_q) ? point_x : max_x_q;
			nmin_y = (point_y < min_y_q) ? point_y : min_y_q;
			nmax_y = (point_y > max_y_q) ? point_y : max_y_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q <= 1'b0;
			close_pulse <= 1'b0;
			min_x_q <= '0;
			max_x_q <= '0;
			min_y_q <= '0;
			max_y_q <= '0;
		end else begin
			close_pulse <= in_take && last_point;
			if (in_take) begin
				open_q <= !last_point;
				min_x_q <= nmin_x;
				max_x_q <= nmax_x;
				min_y_q <= nmin_y;
				max_y_q <= nmax_y;
			end
		end
	end

	assign min_x = min_x_q;
	assign max_x = max_x_q;
	assign min_y = min_y_q;
	assign max_y = max_y_q;

endmodule

// ----- hw/rtl/gpb_back.sv -----
// gpb_back: shared restoring divider that turns one polygon box into five outputs
// one quotient bit per cycle; depends on gpb_pkg
module gpb_back #(
	parameter int COORD_BITS = gpb_pkg::COORD_BITS_DEF,
	parameter int OUT_FRAC_BITS = gpb_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic job_valid,
	output logic job_ready,
	input  logic signed [COORD_BITS-1:0] min_x,
	input  logic signed [COORD_BITS-1:0] max_x,
	input  logic signed [COORD_BITS-1:0] min_y,
	input  logic signed [COORD_BITS-1:0] max_y,
	input  logic [10:0] half_w,
	input  logic [10:0] half_h,
	input  logic [19:0] focal,
	input  logic [17:0] cam_h,
	output logic res_valid,
	input  logic res_take,
	output logic res_status,
	output logic [31:0] res_w,
	output logic [31:0] res_h,
	output logic [31:0] res_fwd,
	output logic [31:0] res_left,
	output logic [31:0] res_up
);

	localparam int NB = gpb_pkg::NUM_BITS;
	localparam int DB = gpb_pkg::DEN_BITS;
	localparam int SH = 25 - OUT_FRAC_BITS;
	localparam int CNT_BITS = $clog2(NB + 1);

	gpb_pkg::div_state_t st_q, st_d;

	logic signed [16:0] dy_q, dx_q, dr_q, sx_q, sy_q;
	logic [19:0] focal_q;
	logic [17:0] cam_q;
	logic [2:0] out_idx_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic [NB-1:0] num_q, quo_q;
	logic [DB:0] rem_q;
	logic [DB-1:0] den_q;
	logic neg_q;
	logic [31:0] outs_q [gpb_pkg::NUM_OUTS];
	logic status_q, valid_q;

	logic signed [31:0] mult;
	logic signed [50:0] prod;
	logic [NB-1:0] mag;
	logic [DB:0] trial;
	logic last_out;

	always_comb begin
		case (out_idx_q)
			3'd0: mult = 32'(dx_q) <<< 9;
			3'd1: mult = 32'(dr_q) <<< 9;
			3'd2: mult = (32'($signed({1'b0, focal_q})) <<< 1) + (32'(dx_q) <<< 8);
			3'd3: mult = -(32'(sx_q) <<< 8);
			default: mult = 32'(sy_q) <<< 8;
		endcase
		prod = 51'($signed({1'b0, cam_q})) * 51'(mult);
		mag = prod[50] ? NB'(-prod) : NB'(prod);
		trial = {rem_q[DB-1:0], num_q[NB-1]} - {1'b0, den_q};
		last_out = (out_idx_q == 3'(gpb_pkg::NUM_OUTS - 1));
	end

	always_comb begin
		st_d = st_q;
		case (st_q)
			gpb_pkg::DIV_IDLE: if (job_valid && !valid_q) begin
				st_d = gpb_pkg::DIV_LOAD;
			end
			gpb_pkg::DIV_LOAD: begin
				if (dy_q <= 0) st_d = gpb_pkg::DIV_DONE;
				else st_d = gpb_pkg::DIV_RUN;
			end
			gpb_pkg::DIV_RUN: begin
				if (cnt_q == CNT_BITS'(1)) st_d = last_out ? gpb_pkg::DIV_DONE : gpb_pkg::DIV_LOAD;
			end
			gpb_pkg::DIV_DONE: st_d = gpb_pkg::DIV_IDLE;
			default: st_d = gpb_pkg::DIV_IDLE;
		endcase
	end

	always_comb begin
		job_ready = (st_q == gpb_pkg::DIV_IDLE) && !valid_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= gpb_pkg::DIV_IDLE;
			valid_q <= 1'b0;
			out_idx_q <= '0;
			cnt_q <= '0;
		end else begin
			st_q <= st_d;
			if (res_take) valid_q <= 1'b0;
			case (st_q)
				gpb_pkg::DIV_IDLE: out_idx_q <= '0;
				gpb_pkg::DIV_LOAD: cnt_q <= CNT_BITS'(NB);
				gpb_pkg::DIV_RUN: begin
					cnt_q <= cnt_q - CNT_BITS'(1);
					if (cnt_q == CNT_BITS'(1)) out_idx_q <= out_idx_q + 3'd1;
				end
				gpb_pkg::DIV_DONE: valid_q <= 1'b1;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (st_q)
			gpb_pkg::DIV_IDLE: if (job_valid && !valid_q) begin
				dy_q <= 17'(max_y) - 17'($signed({1'b0, half_h}));
				dx_q <= 17'(max_x) - 17'(min_x);
				dr_q <= 17'(max_y) - 17'(min_y);
				sx_q <= 17'(min_x) + 17'(max_x) - 17'($signed({1'b0, half_w, 1'b0}));
				sy_q <= 17'($signed({1'b0, half_h, 1'b0})) - 17'(min_y) - 17'(max_y);
				focal_q <= focal;
				cam_q <= cam_h;
			end
			gpb_pkg::DIV_LOAD: begin
				neg_q <= prod[50];
				den_q <= DB'(dy_q[15:0]) << SH;
				num_q <= mag + NB'((DB'(dy_q[15:0]) << SH) >> 1);
				rem_q <= '0;
				quo_q <= '0;
				status_q <= (dy_q <= 0);
			end
			gpb_pkg::DIV_RUN: begin
				num_q <= num_q << 1;
				if (!trial[DB]) begin
					rem_q <= trial;
					quo_q <= {quo_q[NB-2:0], 1'b1};
				end else begin
					rem_q <= {rem_q[DB-1:0], num_q[NB-1]};
					quo_q <= {quo_q[NB-2:0], 1'b0};
				end
				if (cnt_q == CNT_BITS'(1))
					outs_q[out_idx_q] <= gpb_pkg::sat_round(neg_q,
						!trial[DB] ? {quo_q[NB-2:0], 1'b1} : {quo_q[NB-2:0], 1'b0});
			end
			default: ;
		endcase
	end

	assign res_valid = valid_q;
	assign res_status = status_q;
	assign res_w = status_q ? '0 : outs_q[0];
	assign res_h = status_q ? '0 : outs_q[1];
	assign res_fwd = status_q ? '0 : outs_q[2];
	assign res_left = status_q ? '0 : outs_q[3];
	assign res_up = status_q ? '0 : outs_q[4];

endmodule

// ----- hw/rtl/ground_plane_box_from_polygon_unit.sv -----
// ground_plane_box_from_polygon_unit: top level of the ground plane box estimator
// depends on gpb_pkg, gpb_front and gpb_back
// Points are taken one per cycle while full is low; the front tracks the bounding box
// and a two-entry queue holds closed polygons for the back, a shared restoring divider
// that produces five outputs at one quotient bit per cycle: a polygon that stands on
// the ground takes one division per output, one off the ground skips the divider.
// Points of the next polygon flow unless two closed polygons wait or one waits as one closes.
module ground_plane_box_from_polygon_unit #(
	parameter int COORD_BITS = gpb_pkg::COORD_BITS_DEF,
	parameter int OUT_FRAC_BITS = gpb_pkg::OUT_FRAC_BITS_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	output logic full,
	input  logic signed [COORD_BITS-1:0] point_x,
	input  logic signed [COORD_BITS-1:0] point_y,
	input  logic last_point,
	output logic empty,
	input  logic pop,
	output logic status,
	output logic signed [31:0] box_width,
	output logic signed [31:0] box_height,
	output logic signed [31:0] center_forward,
	output logic signed [31:0] center_left,
	output logic signed [31:0] center_up,
	input  logic cfg_we,
	input  logic [gpb_pkg::CFG_IDX_BITS-1:0] cfg_index,
	input  logic [gpb_pkg::CFG_DATA_BITS-1:0] cfg_data
);

	logic [10:0] half_w_q, half_h_q;
	logic [19:0] focal_q;
	logic [17:0] cam_h_q;
	logic close_pulse, job_ready, res_valid, in_take, pop_take;
	logic signed [COORD_BITS-1:0] fmin_x, fmax_x, fmin_y, fmax_y;
	logic signed [COORD_BITS-1:0] qx0 [2], qx1 [2], qy0 [2], qy1 [2];
	logic [1:0] qcnt_q;
	logic qrd_q, qwr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			half_w_q <= gpb_pkg::HALF_W_RST;
			half_h_q <= gpb_pkg::HALF_H_RST;
			focal_q <= gpb_pkg::FOCAL_RST;
			cam_h_q <= gpb_pkg::CAM_H_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				gpb_pkg::REG_HALF_W: half_w_q <= cfg_data[10:0];
				gpb_pkg::REG_HALF_H: half_h_q <= cfg_data[10:0];
				gpb_pkg::REG_FOCAL: focal_q <= cfg_data[19:0];
				gpb_pkg::REG_CAM_H: cam_h_q <= cfg_data[17:0];
				default: ;
			endcase
		end
	end

	// one slot is held back for a polygon that closes while the queue fills
	assign full = (qcnt_q != 2'd0) && !(qcnt_q == 2'd1 && !close_pulse);
	assign in_take = push && !full;

	gpb_front #(.COORD_BITS(COORD_BITS)) u_front (
		.clk(clk), .arst_n(arst_n), .in_take(in_take),
		.point_x(point_x), .point_y(point_y), .last_point(last_point),
		.close_pulse(close_pulse),
		.min_x(fmin_x), .max_x(fmax_x), .min_y(fmin_y), .max_y(fmax_y)
	);

	logic job_valid, deq;
	assign job_valid = qcnt_q != 2'd0;
	assign deq = job_valid && job_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qcnt_q <= '0;
			qrd_q <= 1'b0;
			qwr_q <= 1'b0;
		end else begin
			if (close_pulse) qwr_q <= !qwr_q;
			if (deq) qrd_q <= !qrd_q;
			qcnt_q <= qcnt_q + 2'(close_pulse) - 2'(deq);
		end
	end

	always_ff @(posedge clk) begin
		if (close_pulse) begin
			qx0[qwr_q] <= fmin_x;
			qx1[qwr_q] <= fmax_x;
			qy0[qwr_q] <= fmin_y;
			qy1[qwr_q] <= fmax_y;
		end
	end

	assign pop_take = pop && res_valid;

	gpb_back #(.COORD_BITS(COORD_BITS), .OUT_FRAC_BITS(OUT_FRAC_BITS)) u_back (
		.clk(clk), .arst_n(arst_n), .job_valid(job_valid), .job_ready(job_ready),
		.min_x(qx0[qrd_q]), .max_x(qx1[qrd_q]), .min_y(qy0[qrd_q]), .max_y(qy1[qrd_q]),
		.half_w(half_w_q), .half_h(half_h_q), .focal(focal_q), .cam_h(cam_h_q),
		.res_valid(res_valid), .res_take(pop_take), .res_status(status),
		.res_w(box_width), .res_h(box_height), .res_fwd(center_forward),
		.res_left(center_left), .res_up(center_up)
	);

	assign empty = !res_valid;

endmodule

// ----- hw/rtl/gpb_checker.sv -----
// gpb_checker: port level checks for the ground plane box estimator
// depends on ground_plane_box_from_polygon_unit, bound below
module gpb_checker (
	input logic clk,
	input logic arst_n,
	input logic full,
	input logic empty,
	input logic pop,
	input logic status,
	input logic [31:0] box_width
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty) else $error("result dropped without pop");
	a_stable: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> $stable(box_width) && $stable(status))
		else $error("result changed while waiting");
	a_offground: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && status |-> box_width == 32'd0) else $error("off ground box not zero");
	a_reset: assert property (@(posedge clk) !arst_n |-> empty && !full)
		else $error("result present or input blocked in reset");

endmodule

bind ground_plane_box_from_polygon_unit gpb_checker u_gpb_checker (
	.clk(clk), .arst_n(arst_n), .full(full), .empty(empty),
	.pop(pop), .status(status), .box_width(box_width)
);
